### rtl/core/prcs_pkg.sv
// Shared types, widths and helpers of the pairwise rigid consistency score block.
package prcs_pkg;

  localparam int COORD_W = 20;   // signed Q.16 coordinate
  localparam int MAG_W   = 20;   // magnitude of a per-axis difference
  localparam int REG_W   = 16;   // configuration register width
  localparam int IDX_W   = 1;    // configuration register index width
  localparam int SQ_W    = 2 * MAG_W;       // one squared axis
  localparam int SUM_W   = SQ_W + 2;        // sum of three squares
  localparam int ROOT_W  = SUM_W / 2;       // floor square root
  localparam int CUT_W   = REG_W + 2;       // three times the tolerance
  localparam int T2_W    = 2 * REG_W;       // tolerance squared
  localparam int D2_W    = 2 * CUT_W;       // kept length difference squared
  localparam int NUM_W   = T2_W + 4 + 12;   // (9 t^2 - d^2) in Q.12
  localparam int DEN_W   = T2_W + 1;        // 2 t^2
  localparam int SCORE_W = 15;
  localparam int SCORE_MAX = 18432;

  localparam int SQRT_STEPS_DEF = 3;        // root bits per pipeline stage
  localparam int DIV_STEPS_DEF  = 2;        // quotient bits per pipeline stage

  localparam logic [REG_W-1:0] NEAR_LIMIT_RST = 16'd655;
  localparam logic [REG_W-1:0] MATCH_TOL_RST  = 16'd655;

  localparam logic [IDX_W-1:0] REG_NEAR_LIMIT = 1'd0;
  localparam logic [IDX_W-1:0] REG_MATCH_TOL  = 1'd1;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_first_x;
    logic signed [COORD_W-1:0] a_first_y;
    logic signed [COORD_W-1:0] a_first_z;
    logic signed [COORD_W-1:0] a_second_x;
    logic signed [COORD_W-1:0] a_second_y;
    logic signed [COORD_W-1:0] a_second_z;
    logic signed [COORD_W-1:0] b_first_x;
    logic signed [COORD_W-1:0] b_first_y;
    logic signed [COORD_W-1:0] b_first_z;
    logic signed [COORD_W-1:0] b_second_x;
    logic signed [COORD_W-1:0] b_second_y;
    logic signed [COORD_W-1:0] b_second_z;
  } pair_item_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               keep;
  } score_item_t;

  // |a - b| of two signed coordinates; always fits MAG_W bits
  function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    abs_diff = d[COORD_W] ? MAG_W'(-d) : MAG_W'(d);
  endfunction

endpackage

### rtl/core/prcs_if.sv
// Valid/ready channel interfaces for pair requests and score results.
interface prcs_pair_if;
  logic                  valid;
  logic                  ready;
  prcs_pkg::pair_item_t  data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface prcs_score_if;
  logic                  valid;
  logic                  ready;
  prcs_pkg::score_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/core/prcs_sqrt.sv
// Pipelined floor square root, a few root bits per stage.
module prcs_sqrt #(
  parameter int RAD_W  = prcs_pkg::SUM_W,
  parameter int STEPS  = prcs_pkg::SQRT_STEPS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [RAD_W-1:0]       value,
  output logic [RAD_W/2-1:0]     root
);
  localparam int ROOT_W = RAD_W / 2;
  localparam int STAGES = (ROOT_W + STEPS - 1) / STEPS;
  localparam int PW     = 2 * STAGES * STEPS;
  localparam int REM_W  = ROOT_W + 3;

  logic [PW-1:0]     rad_s  [STAGES+1];
  logic [REM_W-1:0]  rem_s  [STAGES+1];
  logic [ROOT_W-1:0] root_s [STAGES+1];

  assign rad_s[0]  = PW'(value);
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [PW-1:0]     rad_next;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;
    logic [PW-1:0]     rad_q;
    logic [REM_W-1:0]  rem_q;
    logic [ROOT_W-1:0] root_q;

    always_comb begin
      logic [ROOT_W+1:0] trial;
      rad_next  = rad_s[s];
      rem_next  = rem_s[s];
      root_next = root_s[s];
      for (int k = 0; k < STEPS; k++) begin
        rem_next = {rem_next[REM_W-3:0], rad_next[PW-1 -: 2]};
        rad_next = rad_next << 2;
        trial    = {root_next, 2'b01};
        if (rem_next >= REM_W'(trial)) begin
          rem_next  = rem_next - REM_W'(trial);
          root_next = {root_next[ROOT_W-2:0], 1'b1};
        end else begin
          root_next = {root_next[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q  <= rad_next;
        rem_q  <= rem_next;
        root_q <= root_next;
      end
    end

    assign rad_s[s+1]  = rad_q;
    assign rem_s[s+1]  = rem_q;
    assign root_s[s+1] = root_q;
  end

  assign root = root_s[STAGES];

endmodule

### rtl/core/prcs_div.sv
// Pipelined restoring divider, a few quotient bits per stage.
module prcs_div #(
  parameter int NUM_W = prcs_pkg::NUM_W,
  parameter int DEN_W = prcs_pkg::DEN_W,
  parameter int Q_W   = prcs_pkg::SCORE_W,
  parameter int STEPS = prcs_pkg::DIV_STEPS_DEF
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo
);
  localparam int STAGES = (Q_W + STEPS - 1) / STEPS;
  localparam int NSTEP  = STAGES * STEPS;
  localparam int DW     = (DEN_W + NSTEP - 1 > NUM_W) ? DEN_W + NSTEP - 1 : NUM_W;

  logic [DW-1:0]    rem_s [STAGES+1];
  logic [DW-1:0]    dsh_s [STAGES+1];
  logic [NSTEP-1:0] q_s   [STAGES+1];

  assign rem_s[0] = DW'(num);
  assign dsh_s[0] = DW'(den) << (NSTEP - 1);
  assign q_s[0]   = '0;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DW-1:0]    rem_next, dsh_next;
    logic [NSTEP-1:0] q_next;
    logic [DW-1:0]    rem_q, dsh_q;
    logic [NSTEP-1:0] q_q;

    always_comb begin
      rem_next = rem_s[s];
      dsh_next = dsh_s[s];
      q_next   = q_s[s];
      for (int k = 0; k < STEPS; k++) begin
        if (rem_next >= dsh_next) begin
          rem_next = rem_next - dsh_next;
          q_next   = {q_next[NSTEP-2:0], 1'b1};
        end else begin
          q_next   = {q_next[NSTEP-2:0], 1'b0};
        end
        dsh_next = dsh_next >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= rem_next;
        dsh_q <= dsh_next;
        q_q   <= q_next;
      end
    end

    assign rem_s[s+1] = rem_q;
    assign dsh_s[s+1] = dsh_q;
    assign q_s[s+1]   = q_q;
  end

  assign quo = q_s[STAGES][Q_W-1:0];

endmodule

### rtl/core/pairwise_rigid_consistency_score.sv
// Pairwise rigid consistency score: streaming affinity of two 3D point pairs.
//
// Each request carries two points of cloud A and two of cloud B (signed Q.16 m).
// The block drops the request (score 0, keep 0) when either pair lies within
// near_limit on all three axes, or when the floor lengths of the two pairs
// differ by 3*match_tol or more; otherwise it returns keep 1 and
// score = floor((9t^2 - d^2) * 4096 / (2t^2)). One request enters every cycle
// and exactly one result leaves per request, in order. The square root
// pipeline depth is set by SQRT_STEPS (root bits resolved per stage) and
// the divider pipeline depth by DIV_STEPS (quotient bits per stage).
// When the output is stalled the whole pipeline holds and the input is not
// ready. Write near_limit (index 0) and match_tol (index 1) only while idle.
module pairwise_rigid_consistency_score #(
  parameter int SQRT_STEPS = prcs_pkg::SQRT_STEPS_DEF,
  parameter int DIV_STEPS  = prcs_pkg::DIV_STEPS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [prcs_pkg::IDX_W-1:0]  wr_index,
  input  logic [prcs_pkg::REG_W-1:0]  wr_data,
  prcs_pair_if.sink                   pairs,
  prcs_score_if.source                scores
);
  localparam int MAG_W  = prcs_pkg::MAG_W;
  localparam int SQ_W   = prcs_pkg::SQ_W;
  localparam int SUM_W  = prcs_pkg::SUM_W;
  localparam int ROOT_W = prcs_pkg::ROOT_W;
  localparam int CUT_W  = prcs_pkg::CUT_W;
  localparam int T2_W   = prcs_pkg::T2_W;
  localparam int D2_W   = prcs_pkg::D2_W;
  localparam int NUM_W  = prcs_pkg::NUM_W;
  localparam int DEN_W  = prcs_pkg::DEN_W;
  localparam int SCORE_W = prcs_pkg::SCORE_W;
  localparam int SQRT_ST = (ROOT_W + SQRT_STEPS - 1) / SQRT_STEPS;
  localparam int DIV_ST  = (SCORE_W + DIV_STEPS - 1) / DIV_STEPS;

  // Configuration registers
  logic [prcs_pkg::REG_W-1:0] near_limit, match_tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit <= prcs_pkg::NEAR_LIMIT_RST;
      match_tol  <= prcs_pkg::MATCH_TOL_RST;
    end else if (wr_en) begin
      case (wr_index)
        prcs_pkg::REG_NEAR_LIMIT: near_limit <= wr_data;
        prcs_pkg::REG_MATCH_TOL:  match_tol  <= wr_data;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves when the output register is free
  logic advance;
  assign advance     = !scores.valid || scores.ready;
  assign pairs.ready = advance;

  // Stage 1: per-axis magnitudes and the closeness test
  logic [MAG_W-1:0] da_next [3], db_next [3];
  logic [MAG_W-1:0] da1 [3], db1 [3];
  logic             v1, near1;
  logic             near_next;

  always_comb begin
    da_next[0] = prcs_pkg::abs_diff(pairs.data.a_first_x, pairs.data.a_second_x);
    da_next[1] = prcs_pkg::abs_diff(pairs.data.a_first_y, pairs.data.a_second_y);
    da_next[2] = prcs_pkg::abs_diff(pairs.data.a_first_z, pairs.data.a_second_z);
    db_next[0] = prcs_pkg::abs_diff(pairs.data.b_first_x, pairs.data.b_second_x);
    db_next[1] = prcs_pkg::abs_diff(pairs.data.b_first_y, pairs.data.b_second_y);
    db_next[2] = prcs_pkg::abs_diff(pairs.data.b_first_z, pairs.data.b_second_z);
    near_next  = (da_next[0] < MAG_W'(near_limit) && da_next[1] < MAG_W'(near_limit)
                  && da_next[2] < MAG_W'(near_limit))
              || (db_next[0] < MAG_W'(near_limit) && db_next[1] < MAG_W'(near_limit)
                  && db_next[2] < MAG_W'(near_limit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= pairs.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      da1   <= da_next;
      db1   <= db_next;
      near1 <= near_next;
    end
  end

  // Stage 2: square each axis
  logic [SQ_W-1:0] sa2 [3], sb2 [3];
  logic            v2, near2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        sa2[k] <= da1[k] * da1[k];
        sb2[k] <= db1[k] * db1[k];
      end
      near2 <= near1;
    end
  end

  // Stage 3: squared lengths
  logic [SUM_W-1:0] la3, lb3;
  logic             v3, near3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      la3   <= SUM_W'(sa2[0]) + SUM_W'(sa2[1]) + SUM_W'(sa2[2]);
      lb3   <= SUM_W'(sb2[0]) + SUM_W'(sb2[1]) + SUM_W'(sb2[2]);
      near3 <= near2;
    end
  end

  // Square root pipelines; valid and the drop flag ride alongside
  logic [ROOT_W-1:0] root_a, root_b;
  logic              sq_v [SQRT_ST];
  logic              sq_near [SQRT_ST];

  prcs_sqrt #(.RAD_W(SUM_W), .STEPS(SQRT_STEPS)) u_sqrt_a (
    .clk(clk), .en(advance), .value(la3), .root(root_a)
  );
  prcs_sqrt #(.RAD_W(SUM_W), .STEPS(SQRT_STEPS)) u_sqrt_b (
    .clk(clk), .en(advance), .value(lb3), .root(root_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQRT_ST; k++) sq_v[k] <= 1'b0;
    end else if (advance) begin
      sq_v[0] <= v3;
      for (int k = 1; k < SQRT_ST; k++) sq_v[k] <= sq_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sq_near[0] <= near3;
      for (int k = 1; k < SQRT_ST; k++) sq_near[k] <= sq_near[k-1];
    end
  end

  // Stage 4: length mismatch against three t
  logic [ROOT_W-1:0] len_diff;
  logic [CUT_W-1:0]  cut;
  logic [CUT_W-1:0]  diff4;
  logic              v4, keep4;

  assign len_diff = (root_a > root_b) ? root_a - root_b : root_b - root_a;
  assign cut      = {match_tol, 1'b0} + CUT_W'(match_tol);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (advance) begin
      v4 <= sq_v[SQRT_ST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      keep4 <= !sq_near[SQRT_ST-1] && (len_diff < ROOT_W'(cut));
      diff4 <= len_diff[CUT_W-1:0];   // only kept values matter, and they fit
    end
  end

  // Stage 5: d^2 and t^2
  logic [D2_W-1:0] d2_5;
  logic [T2_W-1:0] t2_5;
  logic            v5, keep5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (advance) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d2_5  <= diff4 * diff4;
      t2_5  <= match_tol * match_tol;
      keep5 <= keep4;
    end
  end

  // Stage 6: numerator and divisor; zero the numerator of a dropped request
  logic [NUM_W-12-1:0] nine_t2;
  logic [NUM_W-1:0]    num6;
  logic [DEN_W-1:0]    den6;
  logic                v6, keep6;

  assign nine_t2 = {t2_5, 3'b000} + (NUM_W-12)'(t2_5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (advance) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      num6  <= keep5 ? {nine_t2 - (NUM_W-12)'(d2_5), 12'd0} : '0;
      den6  <= {t2_5, 1'b0};
      keep6 <= keep5;
    end
  end

  // Divider pipeline
  logic [SCORE_W-1:0] quo;
  logic               dv_v [DIV_ST];
  logic               dv_keep [DIV_ST];

  prcs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(SCORE_W), .STEPS(DIV_STEPS)) u_div (
    .clk(clk), .en(advance), .num(num6), .den(den6), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_ST; k++) dv_v[k] <= 1'b0;
    end else if (advance) begin
      dv_v[0] <= v6;
      for (int k = 1; k < DIV_ST; k++) dv_v[k] <= dv_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dv_keep[0] <= keep6;
      for (int k = 1; k < DIV_ST; k++) dv_keep[k] <= dv_keep[k-1];
    end
  end

  // Output register; holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      scores.valid <= 1'b0;
    end else if (advance) begin
      scores.valid <= dv_v[DIV_ST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      scores.data.keep  <= dv_keep[DIV_ST-1];
      scores.data.score <= dv_keep[DIV_ST-1] ? quo : '0;
    end
  end

  // Checks
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    scores.valid && !scores.data.keep |-> scores.data.score == '0)
    else $error("dropped request carries a nonzero score");

  a_score_max: assert property (@(posedge clk) disable iff (rst)
    scores.valid |-> scores.data.score <= SCORE_W'(prcs_pkg::SCORE_MAX))
    else $error("score above 4.5 in Q.12");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    pairs.valid && pairs.ready |=> v1)
    else $error("accepted request lost at first stage");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(v6) && $stable(keep6))
    else $error("pipeline moved during a stall");

endmodule
